### rtl/srtn_pkg.sv
// Shared types and constants for the SRTN scheduler.
// No dependencies; imported by the interfaces and the scheduler top.
package srtn_pkg;

	localparam int SLOT_W  = 4;
	localparam int BURST_W = 16;
	localparam int TIME_W  = 16;

	localparam logic CMD_ARRIVE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ARRIVE,
		ST_RUN,
		ST_TA,
		ST_WT,
		ST_SCAN,
		ST_DECIDE,
		ST_EMIT
	} state_t;

endpackage

### rtl/srtn_ifs.sv
// Valid/ready channel interfaces for the SRTN scheduler.
// Depends on srtn_pkg for field widths.
interface srtn_in_if import srtn_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               cmd;
	logic [SLOT_W-1:0]  task_slot;
	logic [BURST_W-1:0] burst_len;

	modport source (output valid, cmd, task_slot, burst_len, input ready);
	modport sink   (input valid, cmd, task_slot, burst_len, output ready);
endinterface

interface srtn_out_if import srtn_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] time_now;
	logic [SLOT_W-1:0] run_slot;
	logic              run_valid;
	logic              switched;
	logic              done_valid;
	logic [TIME_W-1:0] finish_time;
	logic [TIME_W-1:0] turnaround;
	logic [TIME_W-1:0] wait_time;

	modport source (output valid, time_now, run_slot, run_valid, switched, done_valid,
		finish_time, turnaround, wait_time, input ready);
	modport sink   (input valid, time_now, run_slot, run_valid, switched, done_valid,
		finish_time, turnaround, wait_time, output ready);
endinterface

### rtl/srtn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srtn_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/srtn_alu.sv
// Shared subtract/compare unit of the SRTN scheduler.
// Gives a - b, the borrow (a < b) and the difference floored at zero.
module srtn_alu #(
	parameter int W = 16
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] diff,
	output logic [W-1:0] pos,
	output logic         borrow
);
	logic [W:0] full;

	assign full   = {1'b0, a} - {1'b0, b};
	assign diff   = full[W-1:0];
	assign borrow = full[W];
	assign pos    = full[W] ? '0 : full[W-1:0];
endmodule

### rtl/srtn_preemptive_scheduler.sv
// SRTN scheduler top: sequencer, slot state and result register.
// Arrival: the ARRIVE state follows the transfer, then IDLE again; no result is produced.
// Tick: RUN, then TA and WT when the running task finishes, then a serial scan of every slot
// through the shared subtractor, DECIDE and EMIT; EMIT loads the result register and waits
// while the held result is not yet taken. New transfers are accepted only in IDLE.
// Reset clears control state and slot valid bits; slot RAMs stay undefined, no clear pass.
module srtn_preemptive_scheduler import srtn_pkg::*; #(
	parameter int MAX_TASKS = 16,
	parameter int TIME_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	srtn_in_if.sink    req,
	srtn_out_if.source rsp
);
	localparam int AW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam logic [CW-1:0]        CNT_END = CW'(MAX_TASKS);
	localparam logic [TIME_BITS-1:0] T_MAX   = '1;
	localparam logic [TIME_BITS-1:0] T_ONE   = TIME_BITS'(1);

	state_t state_q, state_d;

	logic [MAX_TASKS-1:0] valid_q;
	logic [AW-1:0]        cur_q;
	logic                 act_q;
	logic                 sw_q;
	logic [TIME_BITS-1:0] clk_cnt_q;
	logic [TIME_BITS-1:0] cur_rem_q;

	logic [SLOT_W-1:0]    slot_q;
	logic [TIME_BITS-1:0] burst_q;

	logic [TIME_BITS-1:0] res_time_q, res_fin_q, res_ta_q, res_wt_q;
	logic [AW-1:0]        res_slot_q;
	logic                 res_run_q, res_sw_q, res_done_q;

	logic [CW-1:0]        cnt_q;
	logic [AW-1:0]        idx_s1;
	logic                 rd_en_s1;
	logic [AW-1:0]        best_q;
	logic [TIME_BITS-1:0] best_rem_q;
	logic                 best_ok_q;

	logic                 ov_q;
	logic [TIME_W-1:0]    out_time_q, out_fin_q, out_ta_q, out_wt_q;
	logic [SLOT_W-1:0]    out_slot_q;
	logic                 out_run_q, out_sw_q, out_done_q;

	logic [TIME_BITS-1:0] alu_a, alu_b, alu_diff, alu_pos;
	logic                 alu_borrow;

	logic                 rem_we, ab_we;
	logic [AW-1:0]        rem_waddr;
	logic [TIME_BITS-1:0] rem_wdata;
	logic [TIME_BITS-1:0] rem_rd, arr_rd, burst_rd;

	logic [TIME_BITS-1:0] time_inc;
	logic [AW-1:0]        slot_idx;
	logic                 arr_ok;
	logic                 scan_take;
	logic                 out_load;

	assign time_inc  = (clk_cnt_q == T_MAX) ? clk_cnt_q : clk_cnt_q + T_ONE;
	assign slot_idx  = AW'(slot_q);
	assign arr_ok    = (32'(slot_q) < MAX_TASKS) && (burst_q != '0) && !valid_q[slot_idx];
	// candidate: valid, not the running task, and strictly less than best so far
	assign scan_take = rd_en_s1 && valid_q[idx_s1] && !(act_q && idx_s1 == cur_q)
		&& (!best_ok_q || alu_borrow);
	assign out_load  = (state_q == ST_EMIT) && (!ov_q || rsp.ready);

	srtn_alu #(.W(TIME_BITS)) u_alu (
		.a      (alu_a),
		.b      (alu_b),
		.diff   (alu_diff),
		.pos    (alu_pos),
		.borrow (alu_borrow)
	);

	srtn_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_TASKS)) u_rem_ram (
		.clk   (clk),
		.we    (rem_we),
		.waddr (rem_waddr),
		.wdata (rem_wdata),
		.raddr (cnt_q[AW-1:0]),
		.rdata (rem_rd)
	);

	srtn_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_TASKS)) u_arr_ram (
		.clk   (clk),
		.we    (ab_we),
		.waddr (slot_idx),
		.wdata (clk_cnt_q),
		.raddr (cur_q),
		.rdata (arr_rd)
	);

	srtn_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_TASKS)) u_burst_ram (
		.clk   (clk),
		.we    (ab_we),
		.waddr (slot_idx),
		.wdata (burst_q),
		.raddr (cur_q),
		.rdata (burst_rd)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = (req.cmd == CMD_TICK) ? ST_RUN : ST_ARRIVE;
				end
			end
			ST_ARRIVE: state_d = ST_IDLE;
			ST_RUN:    state_d = (act_q && alu_diff == '0) ? ST_TA : ST_SCAN;
			ST_TA:     state_d = ST_WT;
			ST_WT:     state_d = ST_SCAN;
			ST_SCAN:   state_d = (cnt_q == CNT_END) ? ST_DECIDE : ST_SCAN;
			ST_DECIDE: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!ov_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (state_q == ST_IDLE);
		alu_a     = '0;
		alu_b     = '0;
		rem_we    = 1'b0;
		ab_we     = 1'b0;
		rem_waddr = cur_q;
		rem_wdata = alu_diff;
		unique case (state_q)
			ST_ARRIVE: begin
				alu_a     = burst_q;
				alu_b     = cur_rem_q;
				rem_we    = arr_ok;
				ab_we     = arr_ok;
				rem_waddr = slot_idx;
				rem_wdata = burst_q;
			end
			ST_RUN: begin
				alu_a  = cur_rem_q;
				alu_b  = T_ONE;
				rem_we = act_q;
			end
			ST_TA: begin
				alu_a = time_inc;
				alu_b = arr_rd;
			end
			ST_WT: begin
				alu_a = res_ta_q;
				alu_b = burst_rd;
			end
			ST_SCAN: begin
				alu_a = rem_rd;
				alu_b = best_rem_q;
			end
			ST_DECIDE: begin
				alu_a = best_rem_q;
				alu_b = cur_rem_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			valid_q   <= '0;
			cur_q     <= '0;
			act_q     <= 1'b0;
			sw_q      <= 1'b0;
			clk_cnt_q <= '0;
			cur_rem_q <= '0;
			cnt_q     <= '0;
			rd_en_s1  <= 1'b0;
			best_ok_q <= 1'b0;
			ov_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
			if (state_q != ST_SCAN) begin
				cnt_q     <= '0;
				rd_en_s1  <= 1'b0;
				best_ok_q <= 1'b0;
			end
			unique case (state_q)
				ST_ARRIVE: begin
					if (arr_ok) begin
						valid_q[slot_idx] <= 1'b1;
						if (!act_q || alu_borrow) begin
							cur_q     <= slot_idx;
							act_q     <= 1'b1;
							sw_q      <= 1'b1;
							cur_rem_q <= burst_q;
						end
					end
				end
				ST_RUN: begin
					// pending switch is reported now; a finish marks the next one
					sw_q <= act_q && (alu_diff == '0);
					if (act_q) begin
						cur_rem_q <= alu_diff;
						if (alu_diff == '0) begin
							valid_q[cur_q] <= 1'b0;
							act_q          <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					if (cnt_q != CNT_END) begin
						cnt_q <= cnt_q + CW'(1);
					end
					rd_en_s1 <= (cnt_q != CNT_END);
					if (scan_take) begin
						best_ok_q <= 1'b1;
					end
				end
				ST_DECIDE: begin
					clk_cnt_q <= time_inc;
					if (best_ok_q && (!act_q || alu_borrow)) begin
						cur_q     <= best_q;
						act_q     <= 1'b1;
						sw_q      <= 1'b1;
						cur_rem_q <= best_rem_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			slot_q  <= req.task_slot;
			burst_q <= TIME_BITS'(req.burst_len);
		end
		if (state_q == ST_RUN) begin
			res_time_q <= clk_cnt_q;
			res_sw_q   <= sw_q;
			res_run_q  <= act_q;
			res_slot_q <= act_q ? cur_q : '0;
			res_done_q <= act_q && (alu_diff == '0);
			res_fin_q  <= '0;
			res_ta_q   <= '0;
			res_wt_q   <= '0;
		end
		if (state_q == ST_TA) begin
			res_fin_q <= time_inc;
			res_ta_q  <= alu_pos;
		end
		if (state_q == ST_WT) begin
			res_wt_q <= alu_pos;
		end
		if (state_q == ST_SCAN) begin
			idx_s1 <= cnt_q[AW-1:0];
			if (scan_take) begin
				best_q     <= idx_s1;
				best_rem_q <= rem_rd;
			end
		end
		if (out_load) begin
			out_time_q <= TIME_W'(res_time_q);
			out_slot_q <= SLOT_W'(res_slot_q);
			out_run_q  <= res_run_q;
			out_sw_q   <= res_sw_q;
			out_done_q <= res_done_q;
			out_fin_q  <= TIME_W'(res_fin_q);
			out_ta_q   <= TIME_W'(res_ta_q);
			out_wt_q   <= TIME_W'(res_wt_q);
		end
	end

	assign rsp.valid       = ov_q;
	assign rsp.time_now    = out_time_q;
	assign rsp.run_slot    = out_slot_q;
	assign rsp.run_valid   = out_run_q;
	assign rsp.switched    = out_sw_q;
	assign rsp.done_valid  = out_done_q;
	assign rsp.finish_time = out_fin_q;
	assign rsp.turnaround  = out_ta_q;
	assign rsp.wait_time   = out_wt_q;

	a_new_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> $past(state_q) == ST_EMIT)
		else $error("result register loaded outside emit");

	a_running_slot_valid: assert property (@(posedge clk) disable iff (!arst_n)
		act_q |-> valid_q[cur_q])
		else $error("running task occupies an empty slot");

	a_running_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && act_q) |-> cur_rem_q != '0)
		else $error("running task has no remaining work");

	a_done_implies_run: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.done_valid) |-> rsp.run_valid)
		else $error("finish reported on an idle tick");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> state_q != ST_IDLE)
		else $error("transfer accepted but sequencer stayed idle");
endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// tb: self-checking testbench for srtn_preemptive_scheduler (arrivals, ticks, preemption).
// Depends on srtn_pkg and the srtn_in_if / srtn_out_if channel interfaces.
module tb;
	import srtn_pkg::*;

	localparam int NSLOTS       = 16;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 64;
	localparam int RANDOM_ITEMS = 260;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	typedef struct {
		logic               cmd;
		logic [SLOT_W-1:0]  slot;
		logic [BURST_W-1:0] burst;
		bit                 hold;	// hold off until every tick report is back
	} sched_cmd_t;

	typedef struct packed {
		logic [TIME_W-1:0] time_now;
		logic [SLOT_W-1:0] run_slot;
		logic              run_valid;
		logic              switched;
		logic              done_valid;
		logic [TIME_W-1:0] finish_time;
		logic [TIME_W-1:0] turnaround;
		logic [TIME_W-1:0] wait_time;
	} tick_report_t;

	logic clk = 1'b0;
	logic arst_n;

	srtn_in_if  req();
	srtn_out_if rsp();

	srtn_preemptive_scheduler #(.MAX_TASKS(NSLOTS), .TIME_BITS(TIME_W)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// scheduler shadow state
	bit                slot_busy    [NSLOTS];
	logic [TIME_W-1:0] slot_left    [NSLOTS];
	logic [TIME_W-1:0] slot_arrived [NSLOTS];
	logic [TIME_W-1:0] slot_len     [NSLOTS];
	logic [SLOT_W-1:0] run_sel = '0;
	bit                run_on  = 1'b0;
	logic [TIME_W-1:0] now     = '0;
	bit                sw_flag = 1'b0;

	sched_cmd_t   cmd_queue[$];
	tick_report_t tick_reports[$];

	bit cmd_taken, rpt_taken, rpt_shown;
	bit no_idle = 1'b0;
	int send_gap = 0;
	int recv_stall = 0;
	int mismatches = 0;

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 8);
	endfunction

	// least remaining among valid slots other than the running one, lowest slot on ties
	function automatic int best_ready();
		int best;
		best = -1;
		for (int i = 0; i < NSLOTS; i++) begin
			if (!slot_busy[i] || (run_on && i == run_sel))
				continue;
			if (best < 0 || slot_left[i] < slot_left[best])
				best = i;
		end
		return best;
	endfunction

	task automatic schedule_step(input sched_cmd_t c);
		tick_report_t r;
		logic [TIME_W-1:0] fin, ta;
		int best;
		int s;
		if (c.cmd == CMD_ARRIVE) begin
			s = c.slot;
			if (c.burst != '0 && !slot_busy[s]) begin
				slot_busy[s] = 1'b1;
				slot_left[s] = c.burst;
				slot_len[s] = c.burst;
				slot_arrived[s] = now;
				if (!run_on) begin
					run_sel = c.slot;
					run_on = 1'b1;
					sw_flag = 1'b1;
				end else if (c.burst < slot_left[run_sel]) begin
					run_sel = c.slot;
					sw_flag = 1'b1;
				end
			end
		end else begin
			r = '0;
			r.time_now = now;
			r.switched = sw_flag;
			sw_flag = 1'b0;
			if (run_on) begin
				r.run_slot = run_sel;
				r.run_valid = 1'b1;
				if (slot_left[run_sel] != '0)
					slot_left[run_sel] = slot_left[run_sel] - 1'b1;
				if (slot_left[run_sel] == '0) begin
					fin = (now == TIME_MAX) ? now : now + 1'b1;
					ta = (fin >= slot_arrived[run_sel]) ? fin - slot_arrived[run_sel] : '0;
					r.done_valid = 1'b1;
					r.finish_time = fin;
					r.turnaround = ta;
					r.wait_time = (ta >= slot_len[run_sel]) ? ta - slot_len[run_sel] : '0;
					slot_busy[run_sel] = 1'b0;
					run_on = 1'b0;
					sw_flag = 1'b1;
				end
			end
			best = best_ready();
			if (run_on) begin
				if (best >= 0 && slot_left[best] < slot_left[run_sel]) begin
					run_sel = SLOT_W'(best);
					sw_flag = 1'b1;
				end
			end else if (best >= 0) begin
				run_sel = SLOT_W'(best);
				run_on = 1'b1;
				sw_flag = 1'b1;
			end
			now = (now == TIME_MAX) ? now : now + 1'b1;
			tick_reports = {tick_reports, r};
		end
	endtask

	function automatic string fmt_report(tick_report_t r);
		return $sformatf("t=%0d slot=%0d run=%b sw=%b done=%b fin=%0d ta=%0d wt=%0d",
			r.time_now, r.run_slot, r.run_valid, r.switched, r.done_valid,
			r.finish_time, r.turnaround, r.wait_time);
	endfunction

	task automatic log_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic push_arrive(input logic [SLOT_W-1:0] s, input logic [BURST_W-1:0] b,
		input bit h);
		sched_cmd_t c;
		c.cmd = CMD_ARRIVE;
		c.slot = s;
		c.burst = b;
		c.hold = h;
		cmd_queue = {cmd_queue, c};
	endtask

	task automatic push_tick(input bit h);
		sched_cmd_t c;
		c.cmd = CMD_TICK;
		c.slot = SLOT_W'($urandom);	// ignored on a tick
		c.burst = BURST_W'($urandom);
		c.hold = h;
		cmd_queue = {cmd_queue, c};
	endtask

	// sample both channels; predict accepted commands, check accepted reports
	always @(posedge clk) begin : monitor
		sched_cmd_t   in_c;
		tick_report_t got, want;
		cmd_taken = arst_n && req.valid && req.ready;
		rpt_taken = arst_n && rsp.valid && rsp.ready;
		rpt_shown = arst_n && rsp.valid;
		if (cmd_taken) begin
			in_c.cmd = req.cmd;
			in_c.slot = req.task_slot;
			in_c.burst = req.burst_len;
			in_c.hold = 1'b0;
			schedule_step(in_c);
			if ($urandom_range(0, 99) == 0)
				no_idle = !no_idle;
		end
		if (rpt_taken) begin
			got.time_now = rsp.time_now;
			got.run_slot = rsp.run_slot;
			got.run_valid = rsp.run_valid;
			got.switched = rsp.switched;
			got.done_valid = rsp.done_valid;
			got.finish_time = rsp.finish_time;
			got.turnaround = rsp.turnaround;
			got.wait_time = rsp.wait_time;
			if (tick_reports.size() == 0) begin
				log_mismatch($sformatf("report with no tick pending: %s", fmt_report(got)));
			end else begin
				want = tick_reports.pop_front();
				if (got !== want)
					log_mismatch($sformatf("expected %s, got %s",
						fmt_report(want), fmt_report(got)));
			end
		end
	end

	always @(negedge clk) begin : driver
		sched_cmd_t nxt;
		bit v;
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.cmd <= CMD_ARRIVE;
			req.task_slot <= '0;
			req.burst_len <= '0;
		end else begin
			v = req.valid;
			if (v && cmd_taken)
				v = 1'b0;
			if (!v) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (cmd_queue.size() != 0 &&
					!(cmd_queue[0].hold && tick_reports.size() != 0)) begin
					nxt = cmd_queue.pop_front();
					req.cmd <= nxt.cmd;
					req.task_slot <= nxt.slot;
					req.burst_len <= nxt.burst;
					v = 1'b1;
					send_gap = draw_gap();
				end
			end
			req.valid <= v;
		end
	end

	// stall counts down only while a report is presented
	always @(negedge clk) begin : receiver
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rpt_taken)
				recv_stall = draw_gap();
			else if (recv_stall > 0 && rpt_shown)
				recv_stall--;
			rsp.ready <= (recv_stall == 0);
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		int useful;
		int n;
		arst_n = 1'b0;

		// directed: idle ticks, ignored arrivals, preemption, ties, finishes
		push_tick(1'b0);			// nothing ready
		push_arrive(4'd0, 16'd0, 1'b0);		// zero burst, dropped
		push_tick(1'b0);
		push_arrive(4'd5, 16'd3, 1'b0);		// idle arrival takes the CPU
		push_arrive(4'd5, 16'd2, 1'b0);		// occupied slot, dropped
		push_arrive(4'd9, 16'd3, 1'b0);		// equal, no preemption
		push_tick(1'b0);
		push_arrive(4'd2, 16'd1, 1'b0);		// strictly shorter, preempts
		push_arrive(4'd0, 16'd1, 1'b0);		// tie with running, stays
		push_tick(1'b0);
		push_tick(1'b0);
		push_arrive(4'd1, 16'd2, 1'b0);
		push_tick(1'b0);
		push_tick(1'b0);			// finish; the shortest waiting task is picked
		push_arrive(4'd15, 16'd4, 1'b1);
		for (int i = 0; i < 11; i++)
			push_tick(1'b0);		// runs dry, then idle with a switch

		useful = 0;
		while (useful < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: begin
					// noise: zero bursts and likely-occupied slots
					if ($urandom_range(0, 1))
						push_arrive(SLOT_W'($urandom), 16'd0, $urandom_range(0, 49) == 0);
					else
						push_arrive(SLOT_W'($urandom), BURST_W'($urandom_range(1, 12)),
							$urandom_range(0, 49) == 0);
				end
				1, 2, 3: begin
					n = $urandom_range(1, 3);
					for (int i = 0; i < n; i++)
						push_arrive(SLOT_W'($urandom),
							BURST_W'(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
								: $urandom_range(1, 12)),
							$urandom_range(0, 49) == 0);
					useful += n;
				end
				default: begin
					n = $urandom_range(1, 14);
					for (int i = 0; i < n; i++)
						push_tick($urandom_range(0, 49) == 0);
					useful += n;
				end
			endcase
		end

		// drain every task (at most 16 slots of 40 units), then the widest burst
		// and a preemption of it
		push_tick(1'b1);
		for (int i = 0; i < 650; i++)
			push_tick(1'b0);
		push_arrive(4'd15, 16'hFFFF, 1'b1);
		for (int i = 0; i < 4; i++)
			push_tick(1'b0);
		push_arrive(4'd0, 16'd1, 1'b0);
		for (int i = 0; i < 3; i++)
			push_tick(1'b0);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmd_queue.size() != 0 || req.valid)
			@(posedge clk);
		while (tick_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && tick_reports.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
